// ===== hw/rtl/cte_pkg.sv =====
// Package for the cross-track error unit: widths and the structs that travel
// with each word through the root and divide cell chains. No dependencies.
`default_nettype none
package cte_pkg;
	localparam int CoordW   = 32;
	localparam int DiffW    = 33;
	localparam int ProdW    = 66;
	localparam int SumW     = 67;
	localparam int RadW     = 68;
	localparam int RootW    = 34;
	localparam int SqRemW   = 37;
	localparam int MagW     = 66;
	localparam int QuotW    = 32;
	localparam int SqSteps  = RadW / 2;
	localparam int DivSteps = QuotW;

	typedef struct packed {
		logic [MagW-1:0] mag;
		logic            neg;
		logic            adv;
		logic            deg;
		logic            live;
	} cte_sq_side_t;

	typedef struct packed {
		logic [QuotW-1:0] low;
		logic             neg;
		logic             adv;
		logic             deg;
		logic             live;
		logic             big;
	} cte_div_side_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cte_front.sv =====
// Front stages: differences, the six exact products, their sums and the
// advance test. Depends on cte_pkg.
`default_nettype none
module cte_front import cte_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_v,
	input  wire logic signed [CoordW-1:0] pos_x,
	input  wire logic signed [CoordW-1:0] pos_y,
	input  wire logic signed [CoordW-1:0] cur_x,
	input  wire logic signed [CoordW-1:0] cur_y,
	input  wire logic signed [CoordW-1:0] nxt_x,
	input  wire logic signed [CoordW-1:0] nxt_y,
	input  wire logic                     has_next,
	output logic                          out_v,
	output logic [RadW-1:0]               rad,
	output cte_sq_side_t                  side
);
	logic                    v_s1, v_s2, v_s3;
	logic signed [DiffW-1:0] rx_s1, ry_s1, dx_s1, dy_s1;
	logic                    live_s1, deg_s1, live_s2, deg_s2, live_s3, deg_s3;
	logic signed [ProdW-1:0] dxx_s2, dyy_s2, rxdx_s2, rydy_s2, rydx_s2, rxdy_s2;
	logic signed [SumW-1:0]  d2_s3, dot_s3, cross_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			out_v <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1    <= DiffW'(pos_x) - DiffW'(cur_x);
			ry_s1    <= DiffW'(pos_y) - DiffW'(cur_y);
			dx_s1    <= DiffW'(nxt_x) - DiffW'(cur_x);
			dy_s1    <= DiffW'(nxt_y) - DiffW'(cur_y);
			live_s1  <= has_next;
			deg_s1   <= (nxt_x == cur_x) && (nxt_y == cur_y);
			dxx_s2   <= dx_s1 * dx_s1;
			dyy_s2   <= dy_s1 * dy_s1;
			rxdx_s2  <= rx_s1 * dx_s1;
			rydy_s2  <= ry_s1 * dy_s1;
			rydx_s2  <= ry_s1 * dx_s1;
			rxdy_s2  <= rx_s1 * dy_s1;
			live_s2  <= live_s1;
			deg_s2   <= deg_s1;
			d2_s3    <= SumW'(dxx_s2) + SumW'(dyy_s2);
			dot_s3   <= SumW'(rxdx_s2) + SumW'(rydy_s2);
			cross_s3 <= SumW'(rydx_s2) - SumW'(rxdy_s2);
			live_s3  <= live_s2;
			deg_s3   <= deg_s2;
			rad       <= RadW'($unsigned(d2_s3));
			side.adv  <= dot_s3 > d2_s3;
			side.neg  <= cross_s3[SumW-1];
			side.mag  <= cross_s3[SumW-1] ? MagW'(-cross_s3) : MagW'(cross_s3);
			side.deg  <= deg_s3;
			side.live <= live_s3;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/cte_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit from two radicand
// bits. Depends on cte_pkg.
`default_nettype none
module cte_sqrt_cell import cte_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire logic [RadW-1:0]   in_rad,
	input  wire logic [SqRemW-1:0] in_rem,
	input  wire logic [RootW-1:0]  in_root,
	input  wire cte_sq_side_t      in_side,
	output logic                   out_v,
	output logic [RadW-1:0]        out_rad,
	output logic [SqRemW-1:0]      out_rem,
	output logic [RootW-1:0]       out_root,
	output cte_sq_side_t           out_side
);
	logic [SqRemW-1:0] cur, trial;
	logic              ge;

	always_comb begin
		cur   = {in_rem[SqRemW-3:0], in_rad[RadW-1:RadW-2]};
		trial = {1'b0, in_root, 2'b01};
		ge    = cur >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rad  <= {in_rad[RadW-3:0], 2'b00};
			out_rem  <= ge ? cur - trial : cur;
			out_root <= {in_root[RootW-2:0], ge};
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/cte_div_cell.sv =====
// One cell of the restoring divide chain: settles one quotient bit.
// Depends on cte_pkg.
`default_nettype none
module cte_div_cell import cte_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_v,
	input  wire logic [RootW-1:0] in_rem,
	input  wire logic [RootW-1:0] in_s,
	input  wire logic [QuotW-1:0] in_q,
	input  wire cte_div_side_t    in_side,
	output logic                  out_v,
	output logic [RootW-1:0]      out_rem,
	output logic [RootW-1:0]      out_s,
	output logic [QuotW-1:0]      out_q,
	output cte_div_side_t         out_side
);
	logic [RootW:0] cur, diff;
	logic           ge;

	always_comb begin
		cur  = {in_rem, in_side.low[QuotW-1]};
		ge   = cur >= {1'b0, in_s};
		diff = cur - {1'b0, in_s};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem       <= ge ? diff[RootW-1:0] : cur[RootW-1:0];
			out_s         <= in_s;
			out_q         <= {in_q[QuotW-2:0], ge};
			out_side.low  <= {in_side.low[QuotW-2:0], 1'b0};
			out_side.neg  <= in_side.neg;
			out_side.adv  <= in_side.adv;
			out_side.deg  <= in_side.deg;
			out_side.live <= in_side.live;
			out_side.big  <= in_side.big;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/cross_track_error_unit.sv =====
// A word passes through cte_front, 34 square root cells, a divide load
// register, 32 divide cells and the output register. Throughput: one word
// per cycle; the whole chain advances while the output register is empty or
// being taken, so in_ready follows out_ready.
// Reset is asynchronous and clears every valid bit; payload is not reset.
// Top level; depends on cte_pkg, cte_front, cte_sqrt_cell and cte_div_cell.
`default_nettype none
module cross_track_error_unit import cte_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [CoordW-1:0] pos_x,
	input  wire logic signed [CoordW-1:0] pos_y,
	input  wire logic signed [CoordW-1:0] cur_x,
	input  wire logic signed [CoordW-1:0] cur_y,
	input  wire logic signed [CoordW-1:0] nxt_x,
	input  wire logic signed [CoordW-1:0] nxt_y,
	input  wire logic                     has_next,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [CoordW-1:0]      cte,
	output logic                          advance,
	output logic                          degenerate
);
	logic en;
	logic              sq_v    [SqSteps+1];
	logic [RadW-1:0]   sq_rad  [SqSteps+1];
	logic [SqRemW-1:0] sq_rem  [SqSteps+1];
	logic [RootW-1:0]  sq_root [SqSteps+1];
	cte_sq_side_t      sq_side [SqSteps+1];
	logic              dv_v    [DivSteps+1];
	logic [RootW-1:0]  dv_rem  [DivSteps+1];
	logic [RootW-1:0]  dv_s    [DivSteps+1];
	logic [QuotW-1:0]  dv_q    [DivSteps+1];
	cte_div_side_t     dv_side [DivSteps+1];
	logic [QuotW-1:0]  q;
	cte_div_side_t     fs;
	logic [QuotW-1:0]  res;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign dv_q[0]    = '0;

	cte_front u_front (
		.clk, .arst_n, .en, .in_v(in_valid),
		.pos_x, .pos_y, .cur_x, .cur_y, .nxt_x, .nxt_y, .has_next,
		.out_v(sq_v[0]), .rad(sq_rad[0]), .side(sq_side[0])
	);

	for (genvar i = 0; i < SqSteps; i++) begin : g_sq
		cte_sqrt_cell u_cell (
			.clk, .arst_n, .en,
			.in_v(sq_v[i]), .in_rad(sq_rad[i]), .in_rem(sq_rem[i]),
			.in_root(sq_root[i]), .in_side(sq_side[i]),
			.out_v(sq_v[i+1]), .out_rad(sq_rad[i+1]), .out_rem(sq_rem[i+1]),
			.out_root(sq_root[i+1]), .out_side(sq_side[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[SqSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0]         <= sq_root[SqSteps];
			dv_rem[0]       <= sq_side[SqSteps].mag[MagW-1:QuotW];
			dv_side[0].low  <= sq_side[SqSteps].mag[QuotW-1:0];
			dv_side[0].neg  <= sq_side[SqSteps].neg;
			dv_side[0].adv  <= sq_side[SqSteps].adv;
			dv_side[0].deg  <= sq_side[SqSteps].deg;
			dv_side[0].live <= sq_side[SqSteps].live;
			dv_side[0].big  <= sq_side[SqSteps].mag >= {sq_root[SqSteps], {QuotW{1'b0}}};
		end
	end

	for (genvar i = 0; i < DivSteps; i++) begin : g_dv
		cte_div_cell u_cell (
			.clk, .arst_n, .en,
			.in_v(dv_v[i]), .in_rem(dv_rem[i]), .in_s(dv_s[i]),
			.in_q(dv_q[i]), .in_side(dv_side[i]),
			.out_v(dv_v[i+1]), .out_rem(dv_rem[i+1]), .out_s(dv_s[i+1]),
			.out_q(dv_q[i+1]), .out_side(dv_side[i+1])
		);
	end

	always_comb begin
		q  = dv_q[DivSteps];
		fs = dv_side[DivSteps];
		if (fs.neg) begin
			res = (fs.big || q > {1'b1, {(QuotW-1){1'b0}}}) ?
				{1'b1, {(QuotW-1){1'b0}}} : QuotW'(-q);
		end else begin
			res = (fs.big || q[QuotW-1]) ? {1'b0, {(QuotW-1){1'b1}}} : q;
		end
		if (!fs.live || fs.deg) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cte        <= $signed(res);
			advance    <= fs.live && !fs.deg && fs.adv;
			degenerate <= fs.live && fs.deg;
		end
	end

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cte) && $stable(advance))
		else $error("result word changed while stalled");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> cte == '0 && !advance)
		else $error("degenerate word carries an error or advance");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not track the output stage");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/cross_track_error_unit_tb.sv =====
// Self-checking testbench for cross_track_error_unit: random and directed geometry words
// are checked against an internal exact-arithmetic predictor of the cross-track error.
// Depends on cte_pkg and the cross_track_error_unit RTL.
`timescale 1ns / 1ps
`default_nettype none
module cross_track_error_unit_tb;
	import cte_pkg::*;

	typedef struct {
		logic signed [CoordW-1:0] px, py, cx, cy, nx, ny;
		logic                     hn;
	} geo_word_t;

	typedef struct {
		logic signed [CoordW-1:0] cte;
		logic                     adv;
		logic                     deg;
	} track_res_t;

	localparam int TailCycles = 200;
	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CoordW-1:0] pos_x = '0, pos_y = '0, cur_x = '0, cur_y = '0;
	logic signed [CoordW-1:0] nxt_x = '0, nxt_y = '0;
	logic has_next = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CoordW-1:0] cte;
	logic advance, degenerate;

	geo_word_t  pending_words[$];
	track_res_t expected_errors[$];
	int mismatches = 0;
	int cycle_count = 0;
	bit stim_done = 1'b0;
	bit quiet_phase = 1'b0;
	int send_gap = 0, recv_gap = 0;

	cross_track_error_unit dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic track_res_t predict_track(geo_word_t w);
		track_res_t r;
		logic signed [DiffW-1:0] rx, ry, dx, dy;
		logic signed [SumW:0] crs, dotp, d2;
		logic [SumW:0] mag, q;
		logic [RootW:0] s, t;
		r.cte = '0;
		r.adv = 1'b0;
		r.deg = 1'b0;
		if (!w.hn) return r;
		rx = DiffW'(w.px) - DiffW'(w.cx);
		ry = DiffW'(w.py) - DiffW'(w.cy);
		dx = DiffW'(w.nx) - DiffW'(w.cx);
		dy = DiffW'(w.ny) - DiffW'(w.cy);
		if (dx == 0 && dy == 0) begin
			r.deg = 1'b1;
			return r;
		end
		d2 = (SumW+1)'(dx) * (SumW+1)'(dx) + (SumW+1)'(dy) * (SumW+1)'(dy);
		dotp = (SumW+1)'(rx) * (SumW+1)'(dx) + (SumW+1)'(ry) * (SumW+1)'(dy);
		crs = (SumW+1)'(ry) * (SumW+1)'(dx) - (SumW+1)'(rx) * (SumW+1)'(dy);
		r.adv = dotp > d2;
		s = '0;
		for (int b = 33; b >= 0; b--) begin
			t = s | ((RootW+1)'(1) << b);
			if ((SumW+1)'(t) * (SumW+1)'(t) <= d2) s = t;
		end
		mag = crs < 0 ? -crs : crs;
		q = mag / s;
		if (crs < 0) r.cte = q > 64'h8000_0000 ? 32'sh8000_0000 : -q[31:0];
		else r.cte = q > 64'h7fff_ffff ? 32'sh7fff_ffff : q[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
		mismatches++;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] near(logic [31:0] v);
		return v + ($urandom_range(0, 8) - 4);
	endfunction

	task automatic add_word(logic [31:0] px, py, cx, cy, nx, ny, logic hn);
		geo_word_t w;
		w.px = px; w.py = py; w.cx = cx; w.cy = cy; w.nx = nx; w.ny = ny; w.hn = hn;
		pending_words.push_back(w);
	endtask

	initial begin
		logic [31:0] a, b;
		add_word(0, 0, 0, 0, 0, 0, 0);
		add_word(32'h7fff_ffff, 32'h8000_0000, 5, 5, 9, 9, 0);
		add_word(1, 1, 3, 3, 3, 3, 1);
		add_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 1);
		add_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0001, 1);
		add_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0001, 32'h8000_0000, 1);
		add_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_fffe, 32'h7fff_ffff, 1);
		add_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 1);
		add_word(32'h0002_0000, 0, 0, 0, 32'h0001_0000, 0, 1);
		add_word(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 1);
		add_word(32'h0000_8000, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1);
		add_word(32'hffff_0000, 32'hffff_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 1);
		add_word(32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0, 1);
		add_word(0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1);
		for (int i = 0; i < 1300; i++) begin
			a = rand_coord();
			b = rand_coord();
			case ($urandom_range(0, 9))
				0: add_word(rand_coord(), rand_coord(), a, b, a, b, $urandom_range(0, 1));
				1: add_word(rand_coord(), rand_coord(), a, b, near(a), near(b), 1);
				2: add_word(near(a), near(b), a, b, rand_coord(), rand_coord(), 1);
				3: add_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), 0);
				default: add_word(rand_coord(), rand_coord(), a, b,
					rand_coord(), rand_coord(), 1);
			endcase
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					geo_word_t w;
					w = pending_words.pop_front();
					expected_errors.push_back(predict_track(w));
					pos_x <= w.px; pos_y <= w.py; cur_x <= w.cx; cur_y <= w.cy;
					nxt_x <= w.nx; nxt_y <= w.ny; has_next <= w.hn;
					in_valid <= 1'b1;
					if (!quiet_phase && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 11);
				end else begin
					in_valid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
			quiet_phase <= pending_words.size() < 200;
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_errors.size() == 0) begin
				report_mismatch("unexpected word", cte, 0);
			end else begin
				track_res_t e;
				e = expected_errors.pop_front();
				if (cte !== e.cte) report_mismatch("cte", cte, e.cte);
				if (advance !== e.adv) report_mismatch("advance", advance, e.adv);
				if (degenerate !== e.deg) report_mismatch("degenerate", degenerate, e.deg);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("[cross_track_error_unit] ERROR");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (expected_errors.size() > 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0 && expected_errors.size() == 0) begin
			$display("[cross_track_error_unit] OK");
		end else begin
			$display("[cross_track_error_unit] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/cte_pkg.sv
hw/rtl/cte_front.sv
hw/rtl/cte_sqrt_cell.sv
hw/rtl/cte_div_cell.sv
hw/rtl/cross_track_error_unit.sv
tb/sv/cross_track_error_unit_tb.sv
